// File: hdl/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants, codes and types for the recency list core.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int unsigned SlotW  = 8;
  localparam int unsigned Slots  = 256;
  localparam int unsigned CountW = 9;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CapReset = 256;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_EVICT  = 3'd1,
    KIND_TOUCH  = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WRITE1,
    S_WRITE2,
    S_DONE
  } fsm_e;

endpackage

// File: hdl/lru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hdl/lru_recency_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_list_core
// Recency list over a slot pool held as a doubly linked list in RAM.
// ----------------------------------------------------------------------------
// One operation at a time. Each goes from acceptance to a valid result
// through these steps: a read of the named slot's links, key, value and the
// free stack top, then two write steps that patch the neighbors' next and prev
// links through the single port of each link RAM, then the result register.
// The in-use flags are flip-flops so a clear takes effect at once and needs
// no clearing pass. A new item is taken only while the core is idle, so the
// next item is not accepted until the last one is through. A finished
// operation holds in its last step while the previous result is still unread.
module lru_recency_list_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lru_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     kind_i,
  input  logic [lru_pkg::KeyW-1:0]       key_i,
  input  logic [lru_pkg::ValW-1:0]       value_i,
  input  logic [lru_pkg::SlotW-1:0]      slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [lru_pkg::SlotW-1:0]      out_slot_o,
  output logic [lru_pkg::KeyW-1:0]       out_key_o,
  output logic [lru_pkg::ValW-1:0]       out_value_o,
  output logic [lru_pkg::CountW-1:0]     entries_o
);

  localparam int unsigned SW = lru_pkg::SlotW;
  localparam int unsigned CW = lru_pkg::CountW;

  lru_pkg::fsm_e state_q, state_d;

  logic [CW-1:0] cap_q;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d, fill_q, fill_d, free_q, free_d;
  logic [lru_pkg::Slots-1:0] use_q, use_d;

  logic [2:0]    kind_q;
  logic [lru_pkg::KeyW-1:0] key_q;
  logic [lru_pkg::ValW-1:0] val_q;
  logic [SW-1:0] slot_q, slot_d;
  logic          go_q, go_d;
  logic          pop_q, pop_d;
  logic [1:0]    st_q, st_d;
  logic [SW-1:0] p_q, p_d, n_q, n_d;

  logic          ovalid_q;
  logic [1:0]    ostat_q;
  logic [SW-1:0] oslot_q;
  logic [lru_pkg::KeyW-1:0] okey_q;
  logic [lru_pkg::ValW-1:0] oval_q;
  logic [CW-1:0] ocnt_q;

  // RAM ports
  logic          pl_we, nl_we, kv_we, fs_we;
  logic [SW-1:0] pl_a, nl_a, kv_a, fs_a, pl_wd, nl_wd, fs_wd;
  logic [SW-1:0] pl_rd, nl_rd, fs_rd;
  logic [lru_pkg::KeyW-1:0] k_rd;
  logic [lru_pkg::ValW-1:0] v_rd;

  lru_ram #(.Width(SW), .Depth(lru_pkg::Slots)) u_prev (
    .clk_i, .we_i(pl_we), .addr_i(pl_a), .wdata_i(pl_wd), .rdata_o(pl_rd));
  lru_ram #(.Width(SW), .Depth(lru_pkg::Slots)) u_next (
    .clk_i, .we_i(nl_we), .addr_i(nl_a), .wdata_i(nl_wd), .rdata_o(nl_rd));
  lru_ram #(.Width(lru_pkg::KeyW), .Depth(lru_pkg::Slots)) u_key (
    .clk_i, .we_i(kv_we), .addr_i(kv_a), .wdata_i(key_q), .rdata_o(k_rd));
  lru_ram #(.Width(lru_pkg::ValW), .Depth(lru_pkg::Slots)) u_val (
    .clk_i, .we_i(kv_we), .addr_i(kv_a), .wdata_i(val_q), .rdata_o(v_rd));
  lru_ram #(.Width(SW), .Depth(lru_pkg::Slots)) u_free (
    .clk_i, .we_i(fs_we), .addr_i(fs_a), .wdata_i(fs_wd), .rdata_o(fs_rd));

  logic accept, is_head, is_tail, lnk;
  logic [CW-1:0] cap_eff;

  assign in_ready_o = (state_q == lru_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cap_eff    = (cap_q > CW'(lru_pkg::Slots)) ? CW'(lru_pkg::Slots) : cap_q;
  assign is_head    = (slot_q == head_q);
  assign is_tail    = (slot_q == tail_q);
  // link at head after unlink (touch) or for a fresh insert
  assign lnk        = (kind_q == lru_pkg::KIND_INSERT) ||
                      (kind_q == lru_pkg::KIND_TOUCH);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lru_pkg::S_IDLE:   if (accept) state_d = lru_pkg::S_READ;
      lru_pkg::S_READ:   state_d = lru_pkg::S_WRITE1;
      lru_pkg::S_WRITE1: state_d = lru_pkg::S_WRITE2;
      lru_pkg::S_WRITE2: state_d = lru_pkg::S_DONE;
      lru_pkg::S_DONE:   if (!ovalid_q || out_ready_i) state_d = lru_pkg::S_IDLE;
      default:           state_d = lru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_d = head_q; tail_d = tail_q; count_d = count_q; fill_d = fill_q;
    free_d = free_q; use_d = use_q; slot_d = slot_q; go_d = go_q; st_d = st_q;
    pop_d = pop_q; p_d = p_q; n_d = n_q;
    pl_we = 1'b0; nl_we = 1'b0; kv_we = 1'b0; fs_we = 1'b0;
    pl_a = slot_q; nl_a = slot_q; kv_a = slot_q; fs_a = slot_q;
    pl_wd = slot_q; nl_wd = slot_q; fs_wd = slot_q;
    unique case (state_q)
      lru_pkg::S_IDLE: begin
        go_d = 1'b0; pop_d = 1'b0; st_d = lru_pkg::ST_OK; slot_d = '0;
        if (accept) begin
          unique case (kind_i) inside
            lru_pkg::KIND_INSERT: begin
              if (count_q >= cap_eff) begin
                st_d = lru_pkg::ST_FULL;
              end else if (free_q != '0) begin
                go_d = 1'b1;
                pop_d = 1'b1;
                free_d = free_q - 1'b1;
              end else if (fill_q < CW'(lru_pkg::Slots)) begin
                go_d = 1'b1;
                slot_d = fill_q[SW-1:0];
                fill_d = fill_q + 1'b1;
              end else begin
                st_d = lru_pkg::ST_FULL;
              end
              fs_a = free_q[SW-1:0] - 1'b1;
            end
            lru_pkg::KIND_EVICT: begin
              if (count_q == '0) st_d = lru_pkg::ST_EMPTY;
              else begin
                go_d = 1'b1;
                slot_d = tail_q;
              end
            end
            lru_pkg::KIND_TOUCH, lru_pkg::KIND_REMOVE: begin
              slot_d = slot_i;
              if (!use_q[slot_i]) st_d = lru_pkg::ST_BAD;
              else go_d = !(kind_i == lru_pkg::KIND_TOUCH && slot_i == head_q);
            end
            lru_pkg::KIND_CLEAR: begin
              use_d = '0; head_d = '0; tail_d = '0; count_d = '0;
              fill_d = '0; free_d = '0;
            end
            default: ;
          endcase
          pl_a = slot_d; nl_a = slot_d; kv_a = slot_d;
        end
      end
      lru_pkg::S_READ: begin
        // read data valid: links of slot, free stack top
        if (go_q && pop_q) slot_d = fs_rd;
        p_d = pl_rd; n_d = nl_rd;
        kv_a = slot_d;
      end
      lru_pkg::S_WRITE1: begin
        kv_a = slot_q;
        if (go_q) begin
          if (kind_q == lru_pkg::KIND_INSERT) begin
            kv_we = 1'b1;
            use_d[slot_q] = 1'b1;
          end else begin
            // unlink: patch next of prev and prev of next, repair head and tail
            if (!is_head) begin
              nl_we = 1'b1; nl_a = p_q; nl_wd = n_q;
            end else head_d = n_q;
            if (!is_tail) begin
              pl_we = 1'b1; pl_a = n_q; pl_wd = p_q;
            end else tail_d = p_q;
            count_d = count_q - 1'b1;
            if (kind_q != lru_pkg::KIND_TOUCH) begin
              use_d[slot_q] = 1'b0;
              fs_we = (free_q < CW'(lru_pkg::Slots));
              fs_a = free_q[SW-1:0]; fs_wd = slot_q;
              if (fs_we) free_d = free_q + 1'b1;
            end
          end
        end
      end
      lru_pkg::S_WRITE2: begin
        if (go_q && lnk) begin
          if (count_q == '0) tail_d = slot_q;
          else begin
            nl_we = 1'b1; nl_a = slot_q; nl_wd = head_q;
            pl_we = 1'b1; pl_a = head_q; pl_wd = slot_q;
          end
          head_d = slot_q;
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru_pkg::S_IDLE;
      cap_q <= CW'(lru_pkg::CapReset);
      head_q <= '0; tail_q <= '0; count_q <= '0; fill_q <= '0; free_q <= '0;
      use_q <= '0; go_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      head_q <= head_d; tail_q <= tail_d; count_q <= count_d;
      fill_q <= fill_d; free_q <= free_d; use_q <= use_d; go_q <= go_d;
      if (state_q == lru_pkg::S_DONE && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; st_q <= st_d; p_q <= p_d; n_q <= n_d; pop_q <= pop_d;
    if (accept) begin
      kind_q <= kind_i; key_q <= key_i; val_q <= value_i;
    end
    if (state_q == lru_pkg::S_DONE && (!ovalid_q || out_ready_i)) begin
      ostat_q <= st_q;
      oslot_q <= slot_q;
      okey_q  <= (go_q && kind_q == lru_pkg::KIND_EVICT) ? k_rd : '0;
      oval_q  <= (go_q && kind_q == lru_pkg::KIND_EVICT) ? v_rd : '0;
      ocnt_q  <= count_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign out_slot_o  = oslot_q;
  assign out_key_o   = okey_q;
  assign out_value_o = oval_q;
  assign entries_o   = ocnt_q;

endmodule

// File: test/tb_lru_recency_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_recency_list_core
// Drives insert, evict, touch, remove, clear and undefined operations into the
// recency list core and checks every result against a behavioral model of the
// list. The capacity register is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_lru_recency_list_core;

  localparam int unsigned SW = lru_pkg::SlotW;
  localparam int unsigned CW = lru_pkg::CountW;
  localparam int unsigned KW = lru_pkg::KeyW;
  localparam int unsigned VW = lru_pkg::ValW;
  localparam int unsigned NS = lru_pkg::Slots;

  typedef struct packed {
    logic [1:0]    status;
    logic [SW-1:0] slot;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
    logic [CW-1:0] entries;
  } lru_result_t;

  class lru_scoreboard;
    logic [SW-1:0] prv [NS];
    logic [SW-1:0] nxt [NS];
    logic [KW-1:0] keys [NS];
    logic [VW-1:0] vals [NS];
    bit            used [NS];
    logic [SW-1:0] free_lifo [NS];
    int unsigned   head, tail, count, fill, nfree, cap;
    lru_result_t   pending [$];
    int            errors;

    function void wipe();
      for (int i = 0; i < NS; i++) used[i] = 0;
      head = 0; tail = 0; count = 0; fill = 0; nfree = 0;
    endfunction

    function void unlink(int unsigned s);
      if (s != head) nxt[prv[s]] = nxt[s];
      if (s != tail) prv[nxt[s]] = prv[s];
      if (s == head) head = 32'(nxt[s]);
      if (s == tail) tail = 32'(prv[s]);
      count--;
    endfunction

    function void link_front(int unsigned s);
      if (count == 0) tail = s;
      else begin
        nxt[s] = SW'(head);
        prv[head] = SW'(s);
      end
      head = s;
      count++;
    endfunction

    function void release_slot(int unsigned s);
      used[s] = 0;
      if (nfree < NS) begin
        free_lifo[nfree] = SW'(s);
        nfree++;
      end
    endfunction

    function void note_operation(logic [2:0] kind, logic [KW-1:0] k, logic [VW-1:0] v,
                                 logic [SW-1:0] sl);
      lru_result_t r;
      int unsigned s;
      int unsigned lim;
      r = '0;
      lim = (cap < NS) ? cap : NS;
      case (kind) inside
        lru_pkg::KIND_INSERT: begin
          if (count >= lim) r.status = lru_pkg::ST_FULL;
          else if (nfree == 0 && fill >= NS) r.status = lru_pkg::ST_FULL;
          else begin
            if (nfree > 0) begin
              nfree--;
              s = 32'(free_lifo[nfree]);
            end else begin
              s = fill;
              fill++;
            end
            keys[s] = k; vals[s] = v; used[s] = 1;
            link_front(s);
            r.slot = SW'(s);
          end
        end
        lru_pkg::KIND_EVICT: begin
          if (count == 0) r.status = lru_pkg::ST_EMPTY;
          else begin
            s = tail;
            unlink(s);
            release_slot(s);
            r.slot = SW'(s); r.key = keys[s]; r.value = vals[s];
          end
        end
        lru_pkg::KIND_TOUCH, lru_pkg::KIND_REMOVE: begin
          r.slot = sl;
          if (!used[sl]) r.status = lru_pkg::ST_BAD;
          else if (kind == lru_pkg::KIND_TOUCH) begin
            if (32'(sl) != head) begin
              unlink(32'(sl));
              link_front(32'(sl));
            end
          end else begin
            unlink(32'(sl));
            release_slot(32'(sl));
          end
        end
        lru_pkg::KIND_CLEAR: wipe();
        default: ;
      endcase
      r.entries = CW'(count);
      pending.push_back(r);
    endfunction

    task check_result(lru_result_t got);
      lru_result_t exp;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.slot !== exp.slot)
        report($sformatf("slot %0d, want %0d", got.slot, exp.slot));
      if (got.key !== exp.key)
        report($sformatf("key %h, want %h", got.key, exp.key));
      if (got.value !== exp.value)
        report($sformatf("value %h, want %h", got.value, exp.value));
      if (got.entries !== exp.entries)
        report($sformatf("entries %0d, want %0d", got.entries, exp.entries));
    endtask

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask
  endclass

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          cfg_we_i = 0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic          in_valid_i = 0;
  logic          in_ready_o;
  logic [2:0]    kind_i = '0;
  logic [KW-1:0] key_i = '0;
  logic [VW-1:0] value_i = '0;
  logic [SW-1:0] slot_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 0;
  logic [1:0]    status_o;
  logic [SW-1:0] out_slot_o;
  logic [KW-1:0] out_key_o;
  logic [VW-1:0] out_value_o;
  logic [CW-1:0] entries_o;

  lru_scoreboard sb = new();
  bit            calm = 0;

  always #1 clk_i = ~clk_i;

  lru_recency_list_core dut (.*);

  // accept results and stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result({status_o, out_slot_o, out_key_o, out_value_o, entries_o});
      out_ready_i <= calm || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_op(logic [2:0] kind, logic [KW-1:0] k, logic [VW-1:0] v,
                         logic [SW-1:0] sl);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; kind_i <= kind; key_i <= k; value_i <= v; slot_i <= sl;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operation(kind, k, v, sl);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned c);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= CW'(c);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cap = c;
  endtask

  function automatic logic [SW-1:0] pick_slot();
    int unsigned s;
    if (sb.count > 0 && $urandom_range(9) < 8) begin
      s = $urandom_range(NS - 1);
      for (int unsigned i = 0; i < NS; i++)
        if (sb.used[(s + i) % NS]) return SW'((s + i) % NS);
    end
    return SW'($urandom_range(NS - 1));
  endfunction

  task automatic random_op(int unsigned bias);
    int unsigned r;
    logic [2:0] kind;
    r = $urandom_range(99);
    if (r < bias) kind = lru_pkg::KIND_INSERT;
    else if (r < bias + 15) kind = lru_pkg::KIND_EVICT;
    else if (r < bias + 35) kind = lru_pkg::KIND_TOUCH;
    else if (r < 97) kind = lru_pkg::KIND_REMOVE;
    else if (r < 99) kind = lru_pkg::KIND_CLEAR;
    else kind = 3'($urandom_range(7, 5));
    send_op(kind, {$urandom, $urandom}, $urandom, pick_slot());
  endtask

  initial begin
    sb.cap = lru_pkg::CapReset;
    sb.wipe();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    send_op(lru_pkg::KIND_EVICT, '0, '0, '0);
    send_op(lru_pkg::KIND_TOUCH, '0, '0, 8'hff);
    send_op(lru_pkg::KIND_REMOVE, '0, '0, 8'h00);
    send_op(lru_pkg::KIND_INSERT, '1, '1, '0);
    send_op(lru_pkg::KIND_INSERT, '0, '0, '0);
    send_op(lru_pkg::KIND_INSERT, 64'h5a5a_a5a5_0f0f_f0f0, 32'h1234_5678, '0);
    send_op(lru_pkg::KIND_TOUCH, '0, '0, 8'd2);
    send_op(lru_pkg::KIND_TOUCH, '0, '0, 8'd0);
    send_op(lru_pkg::KIND_REMOVE, '0, '0, 8'd0);
    send_op(lru_pkg::KIND_REMOVE, '0, '0, 8'd1);
    send_op(lru_pkg::KIND_INSERT, 64'h1, 32'h2, '0);
    send_op(lru_pkg::KIND_EVICT, '0, '0, '0);
    send_op(3'd5, '1, '1, '1);
    send_op(3'd7, '0, '0, '0);
    send_op(lru_pkg::KIND_CLEAR, '0, '0, '0);
    set_capacity(0);
    send_op(lru_pkg::KIND_INSERT, '1, '0, '0);
    set_capacity(1);
    send_op(lru_pkg::KIND_INSERT, '1, '0, '0);
    send_op(lru_pkg::KIND_INSERT, '1, '0, '0);
    send_op(lru_pkg::KIND_EVICT, '0, '0, '0);

    // fill the whole pool, overflow, then churn at full load
    set_capacity(511);
    for (int i = 0; i < NS + 4; i++)
      send_op(lru_pkg::KIND_INSERT, {$urandom, $urandom}, $urandom, '0);
    calm = 1;
    for (int i = 0; i < 150; i++) random_op(30);
    calm = 0;
    set_capacity(3);
    for (int i = 0; i < 50; i++) random_op(30);

    for (int ph = 0; ph < 6; ph++) begin
      set_capacity((ph == 0) ? 256 : (ph == 1) ? 8 : (ph == 2) ? 300 : $urandom_range(1, 256));
      for (int i = 0; i < 200; i++) random_op(ph == 3 ? 20 : 45);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
